### src/cscr_pkg.sv
`timescale 1ns / 1ps

package cscr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int RADIUS_W = 31;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'd1 << FRAC_BITS);

  // Wall top value that selects the plain side wall response.
  localparam logic signed [DATA_W-1:0] WALL_NONE =
    DATA_W'(-64'sd10000 * (64'sd1 <<< FRAC_BITS));

  // A zero length segment gets 0.0001, rounded, and at least one LSB.
  localparam int LEN_EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam logic [DATA_W-1:0] LEN_EPS =
    (LEN_EPS_RAW > 0) ? DATA_W'(LEN_EPS_RAW) : DATA_W'(1);

  // Square root unit: one root bit per stage.
  localparam int SQRT_OUT_W = DATA_W;
  localparam int SQRT_IN_W = 2 * SQRT_OUT_W;
  localparam int SQRT_LAT = SQRT_OUT_W;

  // Divider unit: input stage, one quotient bit per stage, sign stage.
  localparam int DIV_W = 64;
  localparam int DIV_MAG_W = DIV_W - 1;
  localparam int DIVISOR_W = DATA_W;
  localparam int DIV_LAT = DIV_MAG_W + 2;

  localparam logic signed [DATA_W:0] SYM_MAX =
    (DATA_W+1)'((65'sd1 <<< (DATA_W-1)) - 65'sd1);
  localparam logic signed [39:0] OUT_MAX = 40'((65'sd1 <<< (DATA_W-1)) - 65'sd1);
  localparam logic signed [39:0] OUT_MIN = 40'(-(65'sd1 <<< (DATA_W-1)));

  function automatic logic signed [DATA_W-1:0] sat_sym(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] r;
    if (v > SYM_MAX) begin
      r = SYM_MAX;
    end else if (v < -SYM_MAX) begin
      r = -SYM_MAX;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [39:0] v);
    logic signed [39:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

### src/cscr_req_if.sv
`timescale 1ns / 1ps

interface cscr_req_if import cscr_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] seg_start_x;
  logic signed [DATA_W-1:0] seg_start_y;
  logic signed [DATA_W-1:0] seg_end_x;
  logic signed [DATA_W-1:0] seg_end_y;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_y;
  logic signed [DATA_W-1:0] cur_z;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic signed [DATA_W-1:0] prev_z;
  logic signed [DATA_W-1:0] wall_top;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, wall_top,
    input ready
  );

  modport sink (
    input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, wall_top,
    output ready
  );
endinterface

### src/cscr_rsp_if.sv
`timescale 1ns / 1ps

interface cscr_rsp_if import cscr_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;
  logic signed [DATA_W-1:0] new_cur_x;
  logic signed [DATA_W-1:0] new_cur_y;
  logic signed [DATA_W-1:0] new_cur_z;
  logic signed [DATA_W-1:0] new_prev_x;
  logic signed [DATA_W-1:0] new_prev_y;
  logic signed [DATA_W-1:0] new_prev_z;

  modport source (
    output valid, hit, new_cur_x, new_cur_y, new_cur_z,
    output new_prev_x, new_prev_y, new_prev_z,
    input ready
  );

  modport sink (
    input valid, hit, new_cur_x, new_cur_y, new_cur_z,
    input new_prev_x, new_prev_y, new_prev_z,
    output ready
  );
endinterface

### src/circle_segment_collision_response.sv
`timescale 1ns / 1ps

// Circle versus line segment collision response. One word (segment plus body)
// enters per clock and one result word leaves per clock while the output side
// keeps up; a word passes from acceptance to the output register through the
// chain of two bit-serial square root pipelines (one root bit per stage) and
// four rounds of pipelined division (one quotient bit per stage) that the math
// needs in turn. A two-entry output buffer lets the pipeline keep moving for
// one more word when the consumer stalls. The radius register may only be
// written while no word is in flight; there is no clearing pass after reset.
module circle_segment_collision_response import cscr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata,
  cscr_req_if.sink            req,
  cscr_rsp_if.source          rsp
);

  localparam int PIPE_DEPTH = 13 + 2 * SQRT_LAT + 4 * DIV_LAT;

  typedef struct packed {
    logic signed [31:0] sx, sy, cx, cy, cz, px, py, pz, wt;
    logic signed [31:0] dx, dy, velx, vely;
    logic signed [63:0] dot;
    logic [31:0]        lenf;
    logic               rng;
    logic [31:0]        distc;
    logic signed [31:0] vx, vy;
    logic               inr, mlt, mzero;
    logic [31:0]        dl;
    logic [32:0]        scale;
    logic signed [63:0] sdot;
    logic signed [35:0] pushx, pushy;
  } ctx_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] ncx, ncy, ncz, npx, npy, npz;
  } res_t;

  logic [RADIUS_W-1:0] radius;
  logic en;
  logic [PIPE_DEPTH-1:0] vld;

  ctx_t c1, c3, c4, c5, c7, c9, c10, c12;
  ctx_t p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11, p12;
  ctx_t ln1 [SQRT_LAT];
  ctx_t ln2 [DIV_LAT];
  ctx_t ln3 [DIV_LAT];
  ctx_t ln4 [SQRT_LAT];
  ctx_t ln5 [DIV_LAT];
  ctx_t ln6 [DIV_LAT];

  logic signed [31:0] p1_bx, p1_by;
  logic signed [63:0] p2_dd, p2_ee, p2_b1, p2_b2;
  logic [63:0] p3_len2;
  logic [31:0] root1, root2;
  logic signed [63:0] q1, q2x, q2y, q3x, q3y, q3s, q4x, q4y;
  logic signed [65:0] dist66, rn66, lr66, len66;
  logic signed [64:0] m6x, m6y;
  logic signed [63:0] p6_tx, p6_ty;
  logic signed [34:0] vx35, vy35, r35;
  logic signed [63:0] p8_vxx, p8_vyy, p8_s1, p8_s2;
  logic [61:0] p8_rr;
  logic [63:0] m9;
  logic [63:0] p9_m;
  logic [31:0] rd10;
  logic signed [65:0] m11x, m11y;
  logic signed [63:0] p11_tx, p11_ty;
  logic signed [35:0] s36;
  logic signed [67:0] m12x, m12y;
  logic signed [63:0] p12_tx, p12_ty;
  logic signed [39:0] ncx40, ncy40, nvx40, nvy40;
  ctx_t f;
  res_t r13, p13;

  logic out_v, skid_v, take, vin;
  res_t out_w, skid_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  assign en = !skid_v;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], req.valid};
    end
  end

  // Stage 1: saturated differences.
  always_comb begin
    c1 = '0;
    c1.sx = req.seg_start_x;
    c1.sy = req.seg_start_y;
    c1.cx = req.cur_x;
    c1.cy = req.cur_y;
    c1.cz = req.cur_z;
    c1.px = req.prev_x;
    c1.py = req.prev_y;
    c1.pz = req.prev_z;
    c1.wt = req.wall_top;
    c1.dx = sat_sym(33'(req.seg_end_x) - 33'(req.seg_start_x));
    c1.dy = sat_sym(33'(req.seg_end_y) - 33'(req.seg_start_y));
    c1.velx = sat_sym(33'(req.cur_x) - 33'(req.prev_x));
    c1.vely = sat_sym(33'(req.cur_y) - 33'(req.prev_y));
  end

  always_comb begin
    c3 = p2;
    c3.dot = p2_b1 + p2_b2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= c1;
      p1_bx <= sat_sym(33'(req.cur_x) - 33'(req.seg_start_x));
      p1_by <= sat_sym(33'(req.cur_y) - 33'(req.seg_start_y));
      p2 <= p1;
      p2_dd <= p1.dx * p1.dx;
      p2_ee <= p1.dy * p1.dy;
      p2_b1 <= p1_bx * p1.dx;
      p2_b2 <= p1_by * p1.dy;
      p3 <= c3;
      p3_len2 <= $unsigned(p2_dd) + $unsigned(p2_ee);
    end
  end

  cscr_sqrt u_sqrt_len (
    .clk      (clk),
    .en       (en),
    .radicand (p3_len2),
    .root     (root1)
  );

  always_comb begin
    c4 = ln1[SQRT_LAT-1];
    c4.lenf = (root1 == '0) ? LEN_EPS : root1;
  end

  cscr_div u_div_dist (
    .clk      (clk),
    .en       (en),
    .dividend (p4.dot),
    .divisor  (p4.lenf),
    .quotient (q1)
  );

  // Range test along the segment, then clamp into [0, len].
  always_comb begin
    c5 = ln2[DIV_LAT-1];
    dist66 = 66'(q1);
    rn66 = -$signed({35'd0, radius});
    len66 = $signed({34'd0, c5.lenf});
    lr66 = len66 + $signed({35'd0, radius});
    c5.rng = (dist66 > rn66) && (dist66 < lr66);
    if (dist66 > len66) begin
      c5.distc = c5.lenf;
    end else if (dist66[65]) begin
      c5.distc = '0;
    end else begin
      c5.distc = q1[31:0];
    end
  end

  assign m6x = $signed({1'b0, p5.distc}) * p5.dx;
  assign m6y = $signed({1'b0, p5.distc}) * p5.dy;

  cscr_div u_div_nx (
    .clk      (clk),
    .en       (en),
    .dividend (p6_tx),
    .divisor  (p6.lenf),
    .quotient (q2x)
  );

  cscr_div u_div_ny (
    .clk      (clk),
    .en       (en),
    .dividend (p6_ty),
    .divisor  (p6.lenf),
    .quotient (q2y)
  );

  // Offset from the nearest point and the per-axis radius test.
  always_comb begin
    c7 = ln3[DIV_LAT-1];
    r35 = $signed({4'd0, radius});
    vx35 = 35'(c7.cx) - (35'(c7.sx) + 35'(q2x));
    vy35 = 35'(c7.cy) - (35'(c7.sy) + 35'(q2y));
    c7.inr = (vx35 < r35) && (vx35 > -r35) && (vy35 < r35) && (vy35 > -r35);
    c7.vx = vx35[31:0];
    c7.vy = vy35[31:0];
  end

  always_comb begin
    c9 = p8;
    m9 = $unsigned(p8_vxx) + $unsigned(p8_vyy);
    c9.mlt = m9 < {2'b00, p8_rr};
    c9.mzero = (m9 == '0);
    c9.sdot = p8_s1 + p8_s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4 <= c4;
      p5 <= c5;
      p6 <= p5;
      p6_tx <= m6x[63:0];
      p6_ty <= m6y[63:0];
      p7 <= c7;
      p8 <= p7;
      p8_vxx <= p7.vx * p7.vx;
      p8_vyy <= p7.vy * p7.vy;
      p8_s1 <= p7.velx * p7.vx;
      p8_s2 <= p7.vely * p7.vy;
      p8_rr <= radius * radius;
      p9 <= c9;
      p9_m <= m9;
    end
  end

  cscr_sqrt u_sqrt_off (
    .clk      (clk),
    .en       (en),
    .radicand (p9_m),
    .root     (root2)
  );

  always_comb begin
    c10 = ln4[SQRT_LAT-1];
    c10.dl = root2;
    rd10 = {1'b0, radius} - root2;
    c10.scale = {rd10, 1'b0};
  end

  assign m11x = p10.vx * $signed({1'b0, p10.scale});
  assign m11y = p10.vy * $signed({1'b0, p10.scale});

  cscr_div u_div_px (
    .clk      (clk),
    .en       (en),
    .dividend (p11_tx),
    .divisor  ({1'b0, radius}),
    .quotient (q3x)
  );

  cscr_div u_div_py (
    .clk      (clk),
    .en       (en),
    .dividend (p11_ty),
    .divisor  ({1'b0, radius}),
    .quotient (q3y)
  );

  cscr_div u_div_s (
    .clk      (clk),
    .en       (en),
    .dividend (p11.sdot),
    .divisor  (p11.dl),
    .quotient (q3s)
  );

  always_comb begin
    c12 = ln5[DIV_LAT-1];
    c12.pushx = q3x[35:0];
    c12.pushy = q3y[35:0];
    s36 = q3s[35:0];
    m12x = s36 * c12.vx;
    m12y = s36 * c12.vy;
  end

  cscr_div u_div_rx (
    .clk      (clk),
    .en       (en),
    .dividend (p12_tx),
    .divisor  (p12.dl),
    .quotient (q4x)
  );

  cscr_div u_div_ry (
    .clk      (clk),
    .en       (en),
    .dividend (p12_ty),
    .divisor  (p12.dl),
    .quotient (q4y)
  );

  // Final response: wall top landing, or push out and reflect the velocity.
  always_comb begin
    f = ln6[DIV_LAT-1];
    ncx40 = 40'(f.cx) + 40'(f.pushx);
    ncy40 = 40'(f.cy) + 40'(f.pushy);
    if (f.mzero) begin
      nvx40 = 40'(f.velx);
      nvy40 = 40'(f.vely);
    end else begin
      nvx40 = 40'(f.velx) - (40'(q4x) <<< 1);
      nvy40 = 40'(f.vely) - (40'(q4y) <<< 1);
    end
    r13.hit = 1'b0;
    r13.ncx = f.cx;
    r13.ncy = f.cy;
    r13.ncz = f.cz;
    r13.npx = f.px;
    r13.npy = f.py;
    r13.npz = f.pz;
    if (f.rng && f.inr && f.mlt) begin
      if (f.wt != WALL_NONE) begin
        if (f.cz < f.wt && f.pz >= f.wt) begin
          r13.hit = 1'b1;
          r13.ncz = f.wt;
        end
      end else begin
        r13.hit = 1'b1;
        r13.ncx = sat_out(ncx40);
        r13.ncy = sat_out(ncy40);
        r13.npx = sat_out(ncx40 - nvx40);
        r13.npy = sat_out(ncy40 - nvy40);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p10 <= c10;
      p11 <= p10;
      p11_tx <= m11x[63:0];
      p11_ty <= m11y[63:0];
      p12 <= c12;
      p12_tx <= m12x[63:0];
      p12_ty <= m12y[63:0];
      p13 <= r13;
      ln1[0] <= p3;
      ln2[0] <= p4;
      ln3[0] <= p6;
      ln4[0] <= p9;
      ln5[0] <= p11;
      ln6[0] <= p12;
      for (int i = 1; i < SQRT_LAT; i++) begin
        ln1[i] <= ln1[i-1];
        ln4[i] <= ln4[i-1];
      end
      for (int i = 1; i < DIV_LAT; i++) begin
        ln2[i] <= ln2[i-1];
        ln3[i] <= ln3[i-1];
        ln5[i] <= ln5[i-1];
        ln6[i] <= ln6[i-1];
      end
    end
  end

  // Output register plus skid word; the pipeline stops only when the skid is full.
  assign take = !out_v || rsp.ready;
  assign vin = vld[PIPE_DEPTH-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (take) begin
      if (skid_v) begin
        out_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= vin;
      end
    end else if (vin) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_w <= skid_v ? skid_w : p13;
    end else if (vin) begin
      skid_w <= p13;
    end
  end

  assign rsp.valid = out_v;
  assign rsp.hit = out_w.hit;
  assign rsp.new_cur_x = out_w.ncx;
  assign rsp.new_cur_y = out_w.ncy;
  assign rsp.new_cur_z = out_w.ncz;
  assign rsp.new_prev_x = out_w.npx;
  assign rsp.new_prev_y = out_w.npy;
  assign rsp.new_prev_z = out_w.npz;

  assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid word held while the output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !rsp.ready))
    else $error("skid word filled without an output stall");

  assert property (@(posedge clk) disable iff (rst) skid_v |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule

### src/cscr_sqrt.sv
`timescale 1ns / 1ps

module cscr_sqrt import cscr_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam int REM_W = SQRT_OUT_W + 2;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [SQRT_OUT_W-1:0] root;
    logic [SQRT_IN_W-1:0]  rest;
  } sq_t;

  sq_t st [SQRT_LAT];
  sq_t seed;

  // One restoring step: bring down two radicand bits, try root*4+1.
  function automatic sq_t sq_step(input sq_t s);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] t;
    sq_t o;
    r2 = {s.rem, s.rest[SQRT_IN_W-1 -: 2]};
    t = (REM_W+2)'({s.root, 2'b01});
    o.rest = s.rest << 2;
    if (r2 >= t) begin
      o.rem = REM_W'(r2 - t);
      o.root = {s.root[SQRT_OUT_W-2:0], 1'b1};
    end else begin
      o.rem = REM_W'(r2);
      o.root = {s.root[SQRT_OUT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    seed = '0;
    seed.rest = radicand;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step(seed);
      for (int i = 1; i < SQRT_LAT; i++) begin
        st[i] <= sq_step(st[i-1]);
      end
    end
  end

  assign root = st[SQRT_LAT-1].root;

endmodule

### src/cscr_div.sv
`timescale 1ns / 1ps

module cscr_div import cscr_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]    divisor,
  output logic signed [DIV_W-1:0] quotient
);

  typedef struct packed {
    logic                 neg;
    logic [DIVISOR_W-1:0] d;
    logic [DIVISOR_W-1:0] rem;
    logic [DIV_MAG_W-1:0] acc;
  } dv_t;

  dv_t st [DIV_MAG_W+1];
  dv_t seed;
  logic [DIV_W-1:0] mag;
  logic [DIV_W-1:0] qext;

  // acc holds the dividend bits still to come on top and quotient bits below.
  function automatic dv_t dv_step(input dv_t s);
    logic [DIVISOR_W:0] t;
    dv_t o;
    o = s;
    t = {s.rem, s.acc[DIV_MAG_W-1]};
    if (t >= {1'b0, s.d}) begin
      o.rem = DIVISOR_W'(t - {1'b0, s.d});
      o.acc = {s.acc[DIV_MAG_W-2:0], 1'b1};
    end else begin
      o.rem = t[DIVISOR_W-1:0];
      o.acc = {s.acc[DIV_MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    mag = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
    seed.neg = dividend[DIV_W-1];
    seed.d = divisor;
    seed.rem = '0;
    seed.acc = mag[DIV_MAG_W-1:0];
  end

  assign qext = {{(DIV_W-DIV_MAG_W){1'b0}}, st[DIV_MAG_W].acc};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= seed;
      for (int i = 1; i <= DIV_MAG_W; i++) begin
        st[i] <= dv_step(st[i-1]);
      end
      quotient <= st[DIV_MAG_W].neg ? -$signed(qext) : $signed(qext);
    end
  end

endmodule
